@@ design/reorder_buffer_commit_squash_core_macros.svh @@
// Assertion macros used by the checker file.
`ifndef REORDER_BUFFER_COMMIT_SQUASH_CORE_MACROS_SVH
`define REORDER_BUFFER_COMMIT_SQUASH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RBCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define RBCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rbcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rbcs_pkg
// Shared types and constants of the reorder buffer core: item structs,
// controller command and status structs, default sizes.
// ----------------------------------------------------------------------------
package rbcs_pkg;

  // Default depth; the tag fields of the items are six bits wide, so the
  // depth ranges from 4 to 32 entries.
  localparam int ROB_ENTRIES    = 32;
  // Default number of completion ports; the items carry eight.
  localparam int ROB_DONE_PORTS = 8;

  localparam int TAG_FIELD_W  = 6;
  localparam int DONE_FIELD_N = 8;
  localparam int TYPE_W       = 3;
  localparam int DEST_W       = 5;

  typedef struct packed {
    logic                                issue_valid;
    logic [TYPE_W-1:0]                   issue_type;
    logic                                issue_ready;
    logic [DEST_W-1:0]                   issue_dest;
    logic                                issue_halt;
    logic                                squash_valid;
    logic [TAG_FIELD_W-1:0]              squash_tag;
    logic [DONE_FIELD_N-1:0]             done_valid;
    logic [DONE_FIELD_N*TAG_FIELD_W-1:0] done_tags;
  } rbcs_in_t;

  typedef struct packed {
    logic [TAG_FIELD_W-1:0] alloc_tag;
    logic                   issue_refused;
    logic                   commit_valid;
    logic [TAG_FIELD_W-1:0] commit_tag;
    logic [TYPE_W-1:0]      commit_type;
    logic [DEST_W-1:0]      commit_dest;
    logic                   halt_committed;
    logic [DEST_W-1:0]      halt_dest;
    logic                   buffer_full;
    logic                   buffer_empty;
  } rbcs_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
  } rbcs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic slot_free;
  } rbcs_sts_t;

endpackage

@@ design/rbcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// rbcs_ctrl
// Sequencer of the reorder buffer core: capture an item, look up the
// buffer, then apply the update once the result register is free.
// ----------------------------------------------------------------------------
module rbcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  rbcs_pkg::rbcs_sts_t sts,
  output rbcs_pkg::rbcs_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        // take nothing while reset is held
        req_ready   = !rst;
        cmd.capture = req_valid && !rst;
        if (cmd.capture) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        // hold until the result register can take the new item
        if (sts.slot_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/rbcs_datapath.sv @@
// ----------------------------------------------------------------------------
// rbcs_datapath
// Entry storage, pointers, tag match cells and result register of the
// reorder buffer core.
// ----------------------------------------------------------------------------
module rbcs_datapath #(
  parameter int ENTRIES    = rbcs_pkg::ROB_ENTRIES,
  parameter int DONE_PORTS = rbcs_pkg::ROB_DONE_PORTS
) (
  input  logic                clk,
  input  logic                rst,
  input  rbcs_pkg::rbcs_in_t  req,
  input  rbcs_pkg::rbcs_cmd_t cmd,
  output rbcs_pkg::rbcs_sts_t sts,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output rbcs_pkg::rbcs_out_t rsp
);

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int TAG_W   = IDX_W + 1;
  localparam int FIELD_W = rbcs_pkg::TAG_FIELD_W;
  localparam int TYPE_W  = rbcs_pkg::TYPE_W;
  localparam int DEST_W  = rbcs_pkg::DEST_W;
  // ports beyond the item's completion fields never fire
  localparam int NPORTS  = (DONE_PORTS < rbcs_pkg::DONE_FIELD_N) ?
                           DONE_PORTS : rbcs_pkg::DONE_FIELD_N;

  function automatic logic older(input logic [TAG_W-1:0] a, input logic [TAG_W-1:0] b);
    logic res;
    if (a[IDX_W] != b[IDX_W]) begin
      res = a[IDX_W-1:0] > b[IDX_W-1:0];
    end else begin
      res = a[IDX_W-1:0] < b[IDX_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [TAG_W-1:0] tag_after(input logic [TAG_W-1:0] t);
    logic [TAG_W-1:0] res;
    if (t[IDX_W-1:0] == IDX_W'(ENTRIES - 1)) begin
      res = {~t[IDX_W], {IDX_W{1'b0}}};
    end else begin
      res = {t[IDX_W], t[IDX_W-1:0] + IDX_W'(1)};
    end
    return res;
  endfunction

  // captured item
  rbcs_pkg::rbcs_in_t in_q;

  // control state
  logic [TAG_W-1:0]  head;
  logic [TAG_W-1:0]  tail;
  logic              halt_seen;
  logic [DEST_W-1:0] halt_reg;
  logic [TAG_W-1:0]  entry_tag   [ENTRIES];
  logic [ENTRIES-1:0] entry_ready;

  // entry payload memory, written at the tail, read at the head
  logic [TYPE_W-1:0] entry_type [ENTRIES];
  logic [DEST_W-1:0] entry_dest [ENTRIES];
  logic              entry_halt [ENTRIES];

  // lookup results
  logic [ENTRIES-1:0] mark_q;
  logic              sq_hit_q;
  logic              commit_q;
  logic              acc_q;
  logic              full_q;
  logic              empty_q;
  logic [TYPE_W-1:0] rd_type;
  logic [DEST_W-1:0] rd_dest;
  logic              rd_halt;

  // lookup logic
  logic                   empty;
  logic                   full;
  logic                   acc;
  logic                   live;
  logic                   commit;
  logic [TAG_W-1:0]       sq_tag;
  logic [TAG_W-1:0]       port_tag [NPORTS];
  logic [NPORTS-1:0]      port_ok;
  logic [ENTRIES-1:0]     mark;
  logic                   sq_hit;
  logic [TAG_W-1:0]       row;

  always_comb begin
    empty  = head == tail;
    full   = (head[IDX_W-1:0] == tail[IDX_W-1:0]) && !empty;
    acc    = in_q.issue_valid && !full;
    live   = !empty || acc;
    sq_tag = in_q.squash_tag[TAG_W-1:0];
    commit = !empty && entry_ready[head[IDX_W-1:0]] &&
             (!in_q.squash_valid || older(head, sq_tag));
    for (int p = 0; p < NPORTS; p++) begin
      port_tag[p] = in_q.done_tags[FIELD_W*p +: TAG_W];
      port_ok[p]  = in_q.done_valid[p] && live &&
                    (!in_q.squash_valid || older(port_tag[p], sq_tag));
    end
    mark   = '0;
    sq_hit = 1'b0;
    row    = '0;
    // one match cell per entry, against its stored tag or the issuing tag
    for (int k = 0; k < ENTRIES; k++) begin
      if (acc && (tail[IDX_W-1:0] == IDX_W'(k))) begin
        row = tail;
      end else begin
        row = entry_tag[k];
      end
      for (int p = 0; p < NPORTS; p++) begin
        if (port_ok[p] && (port_tag[p] == row) &&
            (port_tag[p][IDX_W-1:0] == IDX_W'(k))) begin
          mark[k] = 1'b1;
        end
      end
      if (in_q.squash_valid && live && (sq_tag == row) &&
          (sq_tag[IDX_W-1:0] == IDX_W'(k))) begin
        sq_hit = 1'b1;
      end
    end
  end

  // update logic
  logic [TAG_W-1:0]  tail_next;
  logic [TAG_W-1:0]  head_next;
  logic              halt_seen_next;
  logic [DEST_W-1:0] halt_reg_next;
  rbcs_pkg::rbcs_out_t rsp_next;

  always_comb begin
    tail_next = tail;
    if (acc_q) begin
      tail_next = tag_after(tail);
    end
    if (sq_hit_q) begin
      tail_next = tag_after(sq_tag);
    end
    head_next      = commit_q ? tag_after(head) : head;
    halt_seen_next = halt_seen;
    halt_reg_next  = halt_reg;
    if (commit_q && rd_halt) begin
      halt_seen_next = 1'b1;
      halt_reg_next  = rd_dest;
    end
    rsp_next.alloc_tag      = acc_q ? FIELD_W'(tail) : '0;
    rsp_next.issue_refused  = in_q.issue_valid && full_q;
    rsp_next.commit_valid   = commit_q;
    rsp_next.commit_tag     = commit_q ? FIELD_W'(head) : '0;
    rsp_next.commit_type    = commit_q ? rd_type : '0;
    rsp_next.commit_dest    = commit_q ? rd_dest : '0;
    rsp_next.halt_committed = halt_seen_next;
    rsp_next.halt_dest      = halt_reg_next;
    rsp_next.buffer_full    = full_q;
    rsp_next.buffer_empty   = empty_q;
  end

  // capture, lookup registers and head read
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_q <= req;
    end
    if (cmd.lookup) begin
      mark_q   <= mark;
      sq_hit_q <= sq_hit;
      commit_q <= commit;
      acc_q    <= acc;
      full_q   <= full;
      empty_q  <= empty;
      rd_type  <= entry_type[head[IDX_W-1:0]];
      rd_dest  <= entry_dest[head[IDX_W-1:0]];
      rd_halt  <= entry_halt[head[IDX_W-1:0]];
    end
  end

  // payload memory write
  always_ff @(posedge clk) begin
    if (cmd.update && acc_q) begin
      entry_type[tail[IDX_W-1:0]] <= in_q.issue_type;
      entry_dest[tail[IDX_W-1:0]] <= in_q.issue_dest;
      entry_halt[tail[IDX_W-1:0]] <= in_q.issue_halt;
    end
  end

  // pointers, tags, ready bits, halt flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      halt_seen   <= 1'b0;
      halt_reg    <= '0;
      entry_ready <= '0;
      for (int k = 0; k < ENTRIES; k++) begin
        entry_tag[k] <= '0;
      end
    end else if (cmd.update) begin
      head      <= head_next;
      tail      <= tail_next;
      halt_seen <= halt_seen_next;
      halt_reg  <= halt_reg_next;
      for (int k = 0; k < ENTRIES; k++) begin
        if (acc_q && (tail[IDX_W-1:0] == IDX_W'(k))) begin
          entry_tag[k]   <= tail;
          entry_ready[k] <= in_q.issue_ready | mark_q[k];
        end else if (mark_q[k]) begin
          entry_ready[k] <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.update) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      rsp <= rsp_next;
    end
  end

  assign sts.slot_free = !rsp_valid || rsp_ready;

endmodule

@@ design/reorder_buffer_commit_squash_core.sv @@
// ----------------------------------------------------------------------------
// reorder_buffer_commit_squash_core
// Circular reorder buffer with phase-bit tags: issue, completion marks,
// squash rewind and head commit, one processor cycle per item.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake            | Payload           | Meaning
//   --------+----------------------+-------------------+-------------------------
//   req     | req_valid/req_ready  | rbcs_pkg::rbcs_in_t  | one processor cycle
//   rsp     | rsp_valid/rsp_ready  | rbcs_pkg::rbcs_out_t | what that cycle did
//
// An item passes through three steps: capture, lookup (match every entry against
// the completion and squash tags, read the head entry), update (write pointers,
// tags, ready bits and memory, load the result register).
// The next item is taken in the cycle after the update; no item is taken while another is at work.
// Reset (rst, synchronous) empties the buffer at once; req_ready is low during it.
// A stalled rsp holds the update step; a new req is still taken while a result waits.
//
module reorder_buffer_commit_squash_core #(
  parameter int ENTRIES    = rbcs_pkg::ROB_ENTRIES,
  parameter int DONE_PORTS = rbcs_pkg::ROB_DONE_PORTS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  rbcs_pkg::rbcs_in_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output rbcs_pkg::rbcs_out_t rsp
);

  // sequencer commands and datapath status
  rbcs_pkg::rbcs_cmd_t cmd;
  rbcs_pkg::rbcs_sts_t sts;

  // drive capture, lookup and update in turn
  rbcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold the entries, pointers and result register
  rbcs_datapath #(
    .ENTRIES    (ENTRIES),
    .DONE_PORTS (DONE_PORTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

@@ design/rbcs_checker.sv @@
// ----------------------------------------------------------------------------
// rbcs_checker
// Port-level checks of the reorder buffer core, bound to the top level.
// ----------------------------------------------------------------------------
`include "reorder_buffer_commit_squash_core_macros.svh"

module rbcs_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input rbcs_pkg::rbcs_out_t rsp
);

  `RBCS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp), "rsp changed while stalled")
  `RBCS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready,
                    "item taken while another is at work")
  `RBCS_ASSERT_NOW(a_full_empty, rsp_valid, !(rsp.buffer_full && rsp.buffer_empty),
                   "buffer full and empty at once")
  `RBCS_ASSERT_NOW(a_refused, rsp_valid && rsp.issue_refused,
                   rsp.buffer_full && (rsp.alloc_tag == '0),
                   "refused issue not from a full buffer")
  `RBCS_ASSERT_NOW(a_no_commit, rsp_valid && !rsp.commit_valid,
                   (rsp.commit_tag == '0) && (rsp.commit_type == '0) &&
                   (rsp.commit_dest == '0), "commit fields set without a commit")

endmodule

bind reorder_buffer_commit_squash_core rbcs_checker u_rbcs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

@@ dv/reorder_buffer_commit_squash_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reorder_buffer_commit_squash_core_tb
// Self-checking bench for the reorder buffer core. Drives processor cycles
// as req items, tracks the buffer state alongside the design and compares
// every rsp item field by field with the outcome worked out for its cycle.
// ----------------------------------------------------------------------------
module reorder_buffer_commit_squash_core_tb;

  // Buffer geometry of the default build. A tag is a slot index with a
  // phase bit on top that flips on every wrap.
  localparam int          SLOTS       = rbcs_pkg::ROB_ENTRIES;
  localparam int          PORTS       = rbcs_pkg::ROB_DONE_PORTS;
  localparam int          IDX_W       = $clog2(SLOTS);
  localparam int unsigned IDX_MSK     = (1 << IDX_W) - 1;
  localparam int unsigned TAG_MSK     = (2 << IDX_W) - 1;
  localparam int          CYCLE_LIMIT = 400_000;
  localparam int          TAG_FW      = rbcs_pkg::TAG_FIELD_W;
  localparam int          FIELD_N     = rbcs_pkg::DONE_FIELD_N;
  localparam int          TYPE_W      = rbcs_pkg::TYPE_W;
  localparam int          DEST_W      = rbcs_pkg::DEST_W;

  // Traffic mixes of the random part, switched every few dozen items.
  typedef enum int {
    MIX_BALANCED,
    MIX_FILL,
    MIX_DRAIN
  } traffic_mix_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  rbcs_pkg::rbcs_in_t  req = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  rbcs_pkg::rbcs_out_t rsp;

  reorder_buffer_commit_squash_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the buffer. Updated once per accepted item, in order, so
  // it always reflects the state after the last accepted processor cycle.
  // Slots start at zero; a slot not yet written is matched with its zero tag.
  // --------------------------------------------------------------------------
  int unsigned       rob_tag  [SLOTS];
  bit                rob_rdy  [SLOTS];
  bit [TYPE_W-1:0]   rob_type [SLOTS];
  bit [DEST_W-1:0]   rob_dest [SLOTS];
  bit                rob_halt [SLOTS];
  int unsigned       head_q    = 0;
  int unsigned       tail_q    = 0;
  bit                halt_flag = 1'b0;
  bit [DEST_W-1:0]   halt_reg  = '0;

  // Outcomes of accepted cycles whose rsp item has not arrived yet.
  rbcs_pkg::rbcs_out_t outcome_q[$];

  int mismatches    = 0;
  int cycle_count   = 0;
  int send_gap_pct  = 34;
  int recv_gap_pct  = 66;
  int stall_left    = 0;

  function automatic int unsigned tag_after(int unsigned t);
    int unsigned s;
    int unsigned p;
    s = (t & IDX_MSK) + 1;
    p = (t >> IDX_W) & 1;
    if (s >= SLOTS) begin
      s = 0;
      p ^= 1;
    end
    return (p << IDX_W) | s;
  endfunction

  // Age order across a wrap: with different phases the larger index is older.
  function automatic bit older(int unsigned a, int unsigned b);
    if (((a ^ b) >> IDX_W) & 1)
      return (a & IDX_MSK) > (b & IDX_MSK);
    return (a & IDX_MSK) < (b & IDX_MSK);
  endfunction

  // Work out one processor cycle: the rsp item it yields, and the new state.
  function automatic rbcs_pkg::rbcs_out_t rob_cycle(rbcs_pkg::rbcs_in_t it);
    rbcs_pkg::rbcs_out_t r;
    int unsigned    head;
    int unsigned    tail;
    int unsigned    hs;
    int unsigned    ts;
    int unsigned    sqt;
    int unsigned    t;
    int unsigned    s;
    int unsigned    row;
    int             k;
    bit             empty;
    bit             full;
    bit             commit;
    bit             acc;
    bit             hit_sq;
    bit [SLOTS-1:0] mark;

    r      = '0;
    head   = head_q & TAG_MSK;
    tail   = tail_q & TAG_MSK;
    sqt    = it.squash_tag & TAG_MSK;
    hs     = head & IDX_MSK;
    ts     = tail & IDX_MSK;
    empty  = head == tail;
    full   = !empty && hs == ts;
    // Hold the head back unless it is strictly older than any squash tag,
    // matching or not.
    commit = !empty && hs < SLOTS && rob_rdy[hs] &&
             (!it.squash_valid || older(head, sqt));
    acc    = it.issue_valid && !full && ts < SLOTS;
    if (commit) begin
      r.commit_type = rob_type[hs];
      r.commit_dest = rob_dest[hs];
    end

    // Match completion ports and the squash against stored tags; the slot
    // issued this cycle counts with its new tag. The live range plays no part.
    hit_sq = 1'b0;
    mark   = '0;
    for (k = 0; k <= PORTS; k++) begin
      if (k == PORTS) begin
        if (!it.squash_valid)
          continue;
        t = sqt;
      end else begin
        if (k >= FIELD_N || !it.done_valid[k])
          continue;
        t = (it.done_tags >> (TAG_FW * k)) & TAG_MSK;
        // Drop marks on entries not strictly older than the squash.
        if (it.squash_valid && !older(t, sqt))
          continue;
      end
      s = t & IDX_MSK;
      if (s >= SLOTS || (empty && !acc))
        continue;
      row = (acc && s == ts) ? tail : rob_tag[s];
      if (row != t)
        continue;
      if (k == PORTS)
        hit_sq = 1'b1;
      else
        mark[s] = 1'b1;
    end

    if (acc) begin
      rob_tag[ts]  = tail;
      rob_type[ts] = it.issue_type;
      rob_rdy[ts]  = it.issue_ready;
      rob_dest[ts] = it.issue_dest;
      rob_halt[ts] = it.issue_halt;
    end
    // A mark beats issue_ready on the entry being issued.
    for (s = 0; s < SLOTS; s++)
      if (mark[s])
        rob_rdy[s] = 1'b1;

    // A matching squash rewinds the tail and wins over the issue advance.
    if (acc)
      tail_q = tag_after(tail);
    if (hit_sq)
      tail_q = tag_after(sqt);

    if (commit) begin
      head_q = tag_after(head);
      if (rob_halt[hs]) begin
        halt_flag = 1'b1;
        halt_reg  = r.commit_dest;
      end
    end

    r.alloc_tag      = acc ? TAG_FW'(tail) : '0;
    r.issue_refused  = it.issue_valid && full;
    r.commit_valid   = commit;
    r.commit_tag     = commit ? TAG_FW'(head) : '0;
    r.halt_committed = halt_flag;
    r.halt_dest      = halt_reg;
    r.buffer_full    = full;
    r.buffer_empty   = empty;
    return r;
  endfunction

  // Pick a tag in the live range (the tail tag included, so issue-cycle hits
  // happen), or an arbitrary one as noise.
  function automatic logic [TAG_FW-1:0] pick_tag(int live_pct);
    int unsigned span;
    span = (tail_q - head_q) & TAG_MSK;
    if (span > SLOTS || $urandom_range(0, 99) >= live_pct)
      return TAG_FW'($urandom_range(0, TAG_MSK));
    return TAG_FW'((head_q + $urandom_range(0, span)) & TAG_MSK);
  endfunction

  function automatic rbcs_pkg::rbcs_in_t issue_item(int unsigned ityp, bit rdy,
                                                    int unsigned dst, bit hlt);
    rbcs_pkg::rbcs_in_t it;
    it             = '0;
    it.issue_valid = 1'b1;
    it.issue_type  = TYPE_W'(ityp);
    it.issue_ready = rdy;
    it.issue_dest  = DEST_W'(dst);
    it.issue_halt  = hlt;
    return it;
  endfunction

  function automatic rbcs_pkg::rbcs_in_t with_done(rbcs_pkg::rbcs_in_t it, int port,
                                                   logic [TAG_FW-1:0] tag);
    it.done_valid[port] = 1'b1;
    it.done_tags[port*TAG_FW +: TAG_FW] = tag;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Entered and left at a falling edge. Valid stays high from one
  // item to the next unless a gap is drawn; whoever pauses the input lowers
  // valid itself at the edge where this task returned.
  // --------------------------------------------------------------------------
  task automatic send_item(rbcs_pkg::rbcs_in_t it);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= it;
    @(posedge clk);
    while (!req_ready)
      @(posedge clk);
    outcome_q.push_back(rob_cycle(it));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    while (outcome_q.size() != 0)
      @(negedge clk);
  endtask

  // Receiver: a long hold-off when one is requested, random gaps otherwise.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each rsp item with the oldest outstanding outcome.
  always @(posedge clk) begin : rsp_check
    rbcs_pkg::rbcs_out_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_ready) begin
      if (outcome_q.size() == 0) begin
        $error("rsp item with no req item outstanding");
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        check_field("alloc_tag", 32'(want.alloc_tag), 32'(rsp.alloc_tag));
        check_field("issue_refused", 32'(want.issue_refused), 32'(rsp.issue_refused));
        check_field("commit_valid", 32'(want.commit_valid), 32'(rsp.commit_valid));
        check_field("commit_tag", 32'(want.commit_tag), 32'(rsp.commit_tag));
        check_field("commit_type", 32'(want.commit_type), 32'(rsp.commit_type));
        check_field("commit_dest", 32'(want.commit_dest), 32'(rsp.commit_dest));
        check_field("halt_committed", 32'(want.halt_committed),
                    32'(rsp.halt_committed));
        check_field("halt_dest", 32'(want.halt_dest), 32'(rsp.halt_dest));
        check_field("buffer_full", 32'(want.buffer_full), 32'(rsp.buffer_full));
        check_field("buffer_empty", 32'(want.buffer_empty), 32'(rsp.buffer_empty));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Walk the special cases from reset with known tags.
  task automatic test_directed_cases();
    rbcs_pkg::rbcs_in_t it;
    // Idle cycle, then squash and completion on an empty buffer: no match.
    it = '0;
    send_item(it);
    it.squash_valid = 1'b1;
    it.done_valid   = 8'h01;
    send_item(it);
    // Issue tag 0 with the top port marking it in the same cycle.
    send_item(with_done(issue_item(7, 1'b0, 31, 1'b0), 7, 6'd0));
    send_item('0);
    // Halt issued ready, then committed: sticky flag and latched dest.
    send_item(issue_item(0, 1'b1, 21, 1'b1));
    send_item('0);
    // Tags 2..4, then a squash on tag 3 with all ports firing: of these only tag 2
    // gets its mark, tag 4 is cut off. Also stale, wrong-phase and unwritten.
    repeat (3)
      send_item(issue_item($urandom_range(0, 7), 1'b0, $urandom_range(0, 31), 1'b0));
    it              = '0;
    it.squash_valid = 1'b1;
    it.squash_tag   = 6'd3;
    it.done_valid   = 8'hFF;
    it.done_tags    = {6'h3F, 6'h15, 6'h00, 6'h3F, 6'h22, 6'd4, 6'd3, 6'd2};
    send_item(it);
    send_item('0);
    // Head is tag 3 and equals the squash: hold both its mark and its commit.
    it              = '0;
    it.squash_valid = 1'b1;
    it.squash_tag   = 6'd3;
    send_item(with_done(it, 5, 6'd3));
    send_item(with_done('0, 6, 6'd3));
    send_item('0);
    // Squash on the tag being issued this cycle: entry kept, tail past it.
    it              = issue_item(2, 1'b1, 0, 1'b0);
    it.squash_valid = 1'b1;
    it.squash_tag   = 6'd4;
    send_item(it);
    // Non-matching squash of the other phase still holds the head.
    it              = '0;
    it.squash_valid = 1'b1;
    it.squash_tag   = 6'h24;
    send_item(it);
    send_item('0);
  endtask

  // Issue without completions until the buffer is full, then a few more
  // that must be refused.
  task automatic test_full_buffer();
    int extra;
    extra = 0;
    while (extra < 3) begin
      if ((head_q ^ tail_q) == (1 << IDX_W))
        extra++;
      send_item(issue_item($urandom_range(0, 7), 1'b0, $urandom_range(0, 31),
                           $urandom_range(0, 99) < 10));
    end
  endtask

  task automatic test_random_traffic(int count);
    rbcs_pkg::rbcs_in_t it;
    traffic_mix_t mix;
    int           issue_pct;
    int           done_pct;
    int           squash_pct;
    int           n;
    int           k;
    issue_pct  = 60;
    done_pct   = 25;
    squash_pct = 4;
    for (n = 0; n < count; n++) begin
      // Switch the mix now and then so the buffer fills and drains.
      if (n % 40 == 0) begin
        mix = traffic_mix_t'($urandom_range(0, 2));
        case (mix)
          MIX_FILL: begin
            issue_pct  = 95;
            done_pct   = 5;
            squash_pct = 1;
          end
          MIX_DRAIN: begin
            issue_pct  = 20;
            done_pct   = 60;
            squash_pct = 3;
          end
          default: begin
            issue_pct  = 60;
            done_pct   = 25;
            squash_pct = 4;
          end
        endcase
      end
      it             = '0;
      it.issue_valid = $urandom_range(0, 99) < issue_pct;
      it.issue_type  = TYPE_W'($urandom_range(0, 7));
      it.issue_ready = $urandom_range(0, 99) < 25;
      it.issue_dest  = DEST_W'($urandom_range(0, 31));
      it.issue_halt  = $urandom_range(0, 99) < 4;
      // Most completions hit live tags; idle ports carry noise tags.
      for (k = 0; k < FIELD_N; k++) begin
        if ($urandom_range(0, 99) < done_pct)
          it = with_done(it, k, pick_tag(85));
        else
          it.done_tags[k*TAG_FW +: TAG_FW] = TAG_FW'($urandom);
      end
      it.squash_valid = $urandom_range(0, 99) < squash_pct;
      it.squash_tag   = pick_tag(80);
      send_item(it);
    end
  endtask

  // Hold rsp off for a long stretch while items keep coming, so the core
  // backs up and stalls req; then pause the input until everything drains.
  task automatic test_output_stall();
    stall_left = 300;
    test_random_traffic(40);
    req_valid <= 1'b0;
    wait_for_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_full_buffer();
    test_output_stall();

    test_random_traffic(590);
    send_gap_pct = 66;
    recv_gap_pct = 34;
    test_random_traffic(590);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_traffic(590);

    req_valid <= 1'b0;
    wait_for_results();
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ reorder_buffer_commit_squash_core.f @@
+incdir+design
design/rbcs_pkg.sv
design/rbcs_ctrl.sv
design/rbcs_datapath.sv
design/reorder_buffer_commit_squash_core.sv
design/rbcs_checker.sv
dv/reorder_buffer_commit_squash_core_tb.sv
